[rtl/core/sle_pkg.sv]
`timescale 1ns / 1ps

package sle_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef logic [VALUE_BITS-1:0] val_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_DUMP   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_ROTATE = 2'd3
	} op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		op_t  op;
		val_t operand;
		cnt_t count;
	} cell_ctrl_t;

endpackage

[rtl/core/sle_cell.sv]
`timescale 1ns / 1ps

module sle_cell (
	input  logic               clk,
	input  sle_pkg::cell_ctrl_t ctrl,
	input  sle_pkg::cnt_t      cell_idx,
	input  sle_pkg::val_t      left_val,
	input  logic               left_ge,
	input  sle_pkg::val_t      right_val,
	input  sle_pkg::val_t      head_val,
	input  logic               found_in,
	output sle_pkg::val_t      val,
	output logic               ge,
	output logic               found_out
);

	sle_pkg::val_t val_q;
	logic          occ;
	logic          has_right;
	logic          is_last;
	logic          at_end;

	assign val       = val_q;
	assign occ       = cell_idx < ctrl.count;
	assign has_right = (cell_idx + sle_pkg::cnt_t'(1)) < ctrl.count;
	assign is_last   = (cell_idx + sle_pkg::cnt_t'(1)) == ctrl.count;
	assign at_end    = cell_idx == ctrl.count;
	assign ge        = occ && (val_q >= ctrl.operand);
	assign found_out = found_in || (occ && (val_q == ctrl.operand));

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			sle_pkg::OP_INSERT: begin
				// everything from the first entry >= operand moves one place right
				if (left_ge)
					val_q <= left_val;
				else if (ge || at_end)
					val_q <= ctrl.operand;
			end
			sle_pkg::OP_REMOVE: begin
				if (found_out && has_right)
					val_q <= right_val;
			end
			sle_pkg::OP_ROTATE: begin
				if (has_right)
					val_q <= right_val;
				else if (is_last)
					val_q <= head_val;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/sle_chain.sv]
`timescale 1ns / 1ps

module sle_chain (
	input  logic                clk,
	input  sle_pkg::cell_ctrl_t ctrl,
	output sle_pkg::val_t       head_val,
	output logic                found
);

	sle_pkg::val_t cval  [sle_pkg::CAPACITY];
	logic          cge   [sle_pkg::CAPACITY];
	logic          cfound[sle_pkg::CAPACITY];

	assign head_val = cval[0];
	assign found    = cfound[sle_pkg::CAPACITY-1];

	for (genvar i = 0; i < sle_pkg::CAPACITY; i++) begin : g_cell
		sle_pkg::val_t lv;
		logic          lg;
		logic          fi;
		sle_pkg::val_t rv;

		if (i == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
			assign fi = 1'b0;
		end else begin : g_mid
			assign lv = cval[i-1];
			assign lg = cge[i-1];
			assign fi = cfound[i-1];
		end

		if (i == sle_pkg::CAPACITY - 1) begin : g_tail
			assign rv = '0;
		end else begin : g_body
			assign rv = cval[i+1];
		end

		sle_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.cell_idx  (sle_pkg::cnt_t'(i)),
			.left_val  (lv),
			.left_ge   (lg),
			.right_val (rv),
			.head_val  (cval[0]),
			.found_in  (fi),
			.val       (cval[i]),
			.ge        (cge[i]),
			.found_out (cfound[i])
		);
	end

endmodule

[rtl/core/sorted_list_engine_unit.sv]
`timescale 1ns / 1ps
// Insert, remove and clear: result registered the cycle after acceptance, one command per
// cycle unless output stalls or a dump runs; the row moves at that edge on insert/remove.
// Dump of N entries: the row rotates one place per beat, N beats after the accept cycle,
// input stalled until the last beat is loaded; an empty dump gives one beat in the next cycle.
// Reset clears the count, dump counter and output valid; cell contents are not reset.
module sorted_list_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] operand_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] element_value,
	output logic [4:0]  entry_count,
	output logic [1:0]  status,
	output logic        last_result
);

	sle_pkg::cnt_t       count_q;
	sle_pkg::cnt_t       dump_rem_q;
	logic                out_valid_q;
	logic [31:0]         elem_q;
	logic [4:0]          ecount_q;
	logic [1:0]          status_q;
	logic                last_q;

	sle_pkg::cell_ctrl_t ctrl;
	sle_pkg::val_t       head_val;
	logic                found;
	logic                slot_free;
	logic                in_acc;
	logic                dump_go;
	logic                full;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (dump_rem_q != '0) || !slot_free;
	assign in_acc    = in_valid && !in_stall;
	assign dump_go   = (dump_rem_q != '0) && slot_free;
	assign full      = count_q >= sle_pkg::cnt_t'(sle_pkg::CAPACITY);

	always_comb begin
		ctrl.op      = sle_pkg::OP_NONE;
		ctrl.operand = sle_pkg::val_t'(operand_value);
		ctrl.count   = count_q;
		if (in_acc) begin
			case (command)
				sle_pkg::CMD_INSERT: ctrl.op = full ? sle_pkg::OP_NONE : sle_pkg::OP_INSERT;
				sle_pkg::CMD_REMOVE: ctrl.op = sle_pkg::OP_REMOVE;
				default:             ctrl.op = sle_pkg::OP_NONE;
			endcase
		end else if (dump_go) begin
			ctrl.op = sle_pkg::OP_ROTATE;
		end
	end

	sle_chain u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.head_val (head_val),
		.found    (found)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dump_rem_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				case (command)
					sle_pkg::CMD_INSERT: begin
						if (!full)
							count_q <= count_q + sle_pkg::cnt_t'(1);
						out_valid_q <= 1'b1;
					end
					sle_pkg::CMD_REMOVE: begin
						if (found)
							count_q <= count_q - sle_pkg::cnt_t'(1);
						out_valid_q <= 1'b1;
					end
					sle_pkg::CMD_CLEAR: begin
						count_q     <= '0;
						out_valid_q <= 1'b1;
					end
					default: begin
						// empty dump answers at once, otherwise beats follow
						dump_rem_q  <= count_q;
						out_valid_q <= (count_q == '0) ? 1'b1 : !slot_free;
					end
				endcase
			end else if (dump_go) begin
				dump_rem_q  <= dump_rem_q - sle_pkg::cnt_t'(1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			elem_q <= '0;
			last_q <= 1'b1;
			case (command)
				sle_pkg::CMD_INSERT: begin
					ecount_q <= full ? 5'(count_q) : 5'(count_q + sle_pkg::cnt_t'(1));
					status_q <= full ? sle_pkg::ST_FULL : sle_pkg::ST_OK;
				end
				sle_pkg::CMD_REMOVE: begin
					ecount_q <= found ? 5'(count_q - sle_pkg::cnt_t'(1)) : 5'(count_q);
					status_q <= found ? sle_pkg::ST_OK : sle_pkg::ST_NOT_FOUND;
				end
				sle_pkg::CMD_CLEAR: begin
					ecount_q <= '0;
					status_q <= sle_pkg::ST_OK;
				end
				default: begin
					ecount_q <= '0;
					status_q <= sle_pkg::ST_EMPTY;
				end
			endcase
		end else if (dump_go) begin
			elem_q   <= 32'(head_val);
			ecount_q <= 5'(count_q);
			status_q <= sle_pkg::ST_OK;
			last_q   <= dump_rem_q == sle_pkg::cnt_t'(1);
		end
	end

	assign out_valid     = out_valid_q;
	assign element_value = elem_q;
	assign entry_count   = ecount_q;
	assign status        = status_q;
	assign last_result   = last_q;

endmodule
